// ===== hw/rtl/um32_pkg.sv =====
// Shared types and constants for the um32 register ALU execute unit.
// Operation codes, internal operation classes and the queue entry type.
// No dependencies.
`default_nettype none

package um32_pkg;

    // Operation codes as they arrive on the cmd field
    localparam logic [2:0] CMD_CMOV = 3'd0;
    localparam logic [2:0] CMD_ADD  = 3'd1;
    localparam logic [2:0] CMD_MUL  = 3'd2;
    localparam logic [2:0] CMD_DIV  = 3'd3;
    localparam logic [2:0] CMD_NAND = 3'd4;
    localparam logic [2:0] CMD_LDI  = 3'd5;

    // Operation classes decided by the front end; unused codes become CLS_NOP
    localparam logic [2:0] CLS_NOP  = 3'd0;
    localparam logic [2:0] CLS_MOVE = 3'd1;
    localparam logic [2:0] CLS_ADD  = 3'd2;
    localparam logic [2:0] CLS_MUL  = 3'd3;
    localparam logic [2:0] CLS_DIV  = 3'd4;
    localparam logic [2:0] CLS_NAND = 3'd5;
    localparam logic [2:0] CLS_LDI  = 3'd6;

    localparam int IDX_W   = 3;
    localparam int IMM_W   = 25;
    localparam int DATA_W  = 32;
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [2:0]       cls;
        logic [IDX_W-1:0] reg_a;
        logic [IDX_W-1:0] reg_b;
        logic [IDX_W-1:0] reg_c;
        logic [IMM_W-1:0] immediate;
    } um32_item_t;

endpackage

`default_nettype wire

// ===== hw/rtl/um32_front.sv =====
// Front end of the um32 execute unit: takes input transfers and classifies them.
// Depends on um32_pkg.
`default_nettype none

module um32_front (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [2:0]             cmd,
    input  logic [2:0]             reg_a,
    input  logic [2:0]             reg_b,
    input  logic [2:0]             reg_c,
    input  logic [24:0]            immediate,
    input  logic                   q_full,
    output logic                   push,
    output um32_pkg::um32_item_t   push_item
);
    import um32_pkg::*;

    logic       front_valid_reg;
    logic       front_valid_next;
    um32_item_t item_reg;
    um32_item_t item_next;
    logic       accept;
    logic [2:0] cls;

    always_comb
    begin
        case (cmd)
            CMD_CMOV: cls = CLS_MOVE;
            CMD_ADD:  cls = CLS_ADD;
            CMD_MUL:  cls = CLS_MUL;
            CMD_DIV:  cls = CLS_DIV;
            CMD_NAND: cls = CLS_NAND;
            CMD_LDI:  cls = CLS_LDI;
            default:  cls = CLS_NOP;
        endcase
    end

    assign in_stall  = front_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = front_valid_reg && !q_full;
    assign push_item = item_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        item_next        = item_reg;
        if (accept)
        begin
            front_valid_next    = 1'b1;
            item_next.cls       = cls;
            item_next.reg_a     = reg_a;
            item_next.reg_b     = reg_b;
            item_next.reg_c     = reg_c;
            item_next.immediate = immediate;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/um32_queue.sv =====
// Short in-order queue between the front and back ends of the um32 unit.
// Depends on um32_pkg.
`default_nettype none

module um32_queue (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  um32_pkg::um32_item_t   push_item,
    input  logic                   pop,
    output um32_pkg::um32_item_t   head,
    output logic                   full,
    output logic                   empty
);
    import um32_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(QUEUE_DEPTH);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(QUEUE_DEPTH - 1);

    um32_item_t       slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == CNT_FULL);
    assign empty   = (count_reg == '0);
    assign head    = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/um32_div.sv =====
// Radix-2 restoring divider for the um32 unit, one quotient bit per cycle.
// Depends on um32_pkg.
`default_nettype none

module um32_div (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic [um32_pkg::DATA_W-1:0]   dividend,
    input  logic [um32_pkg::DATA_W-1:0]   divisor,
    output logic                          done,
    output logic [um32_pkg::DATA_W-1:0]   quotient
);
    import um32_pkg::*;

    localparam int CNT_W = $clog2(DATA_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic [DATA_W-1:0] rem_reg;
    logic [DATA_W-1:0] rem_next;
    logic [DATA_W-1:0] quo_reg;
    logic [DATA_W-1:0] quo_next;
    logic [DATA_W-1:0] dvs_reg;
    logic [DATA_W-1:0] dvs_next;
    logic [DATA_W:0]   shifted;
    logic [DATA_W:0]   diff;
    logic              fits;

    // Bring down the next dividend bit and try a subtraction.
    assign shifted = {rem_reg, quo_reg[DATA_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign fits    = !diff[DATA_W];

    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
            quo_next = {quo_reg[DATA_W-2:0], fits};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_LAST)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/um32_back.sv =====
// Back end of the um32 unit: register file, execution sequencer and result register.
// Depends on um32_pkg and um32_div.
`default_nettype none

module um32_back #(
    parameter int NUM_REGS = 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  um32_pkg::um32_item_t          head,
    input  logic                          empty,
    output logic                          pop,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          wrote,
    output logic [2:0]                    dest_index,
    output logic [31:0]                   dest_value,
    output logic                          error
);
    import um32_pkg::*;

    localparam int RA_W = $clog2(NUM_REGS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RDA  = 3'd1;
    localparam logic [2:0] S_EXEC = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_WB   = 3'd4;

    logic [DATA_W-1:0]   rf_reg [NUM_REGS];
    logic [NUM_REGS-1:0] rf_valid_reg;
    logic [RA_W-1:0]     rd0_addr;
    logic [RA_W-1:0]     rd1_addr;
    logic [DATA_W-1:0]   rd0_data_reg;
    logic [DATA_W-1:0]   rd1_data_reg;
    logic                rf_we;

    logic [2:0]          state_reg;
    logic [2:0]          state_next;
    um32_item_t          item_reg;
    um32_item_t          item_next;
    logic [DATA_W-1:0]   vb_reg;
    logic [DATA_W-1:0]   vb_next;
    logic [DATA_W-1:0]   vc_reg;
    logic [DATA_W-1:0]   vc_next;
    logic [DATA_W-1:0]   res_reg;
    logic [DATA_W-1:0]   res_next;
    logic                wr_reg;
    logic                wr_next;
    logic                err_reg;
    logic                err_next;

    logic                out_valid_reg;
    logic                out_valid_next;
    logic                wrote_reg;
    logic                wrote_next;
    logic [IDX_W-1:0]    dest_index_reg;
    logic [IDX_W-1:0]    dest_index_next;
    logic [DATA_W-1:0]   dest_value_reg;
    logic [DATA_W-1:0]   dest_value_next;
    logic                error_reg;
    logic                error_next;

    logic                out_free;
    logic [2*DATA_W-1:0] product;
    logic                div_start;
    logic                div_done;
    logic [DATA_W-1:0]   div_quotient;

    um32_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (vb_reg),
        .divisor  (vc_reg),
        .done     (div_done),
        .quotient (div_quotient)
    );

    assign out_free   = !out_valid_reg || !out_stall;
    assign pop        = (state_reg == S_IDLE) && !empty;
    assign product    = vb_reg * vc_reg;
    assign div_start  = (state_reg == S_EXEC) && (item_reg.cls == CLS_DIV) && (vc_reg != '0);
    assign rf_we      = (state_reg == S_WB) && out_free && wr_reg;

    assign out_valid  = out_valid_reg;
    assign wrote      = wrote_reg;
    assign dest_index = dest_index_reg;
    assign dest_value = dest_value_reg;
    assign error      = error_reg;

    // Sources B and C are read on popping; A follows on the next cycle.
    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd0_addr = head.reg_b[RA_W-1:0];
            rd1_addr = head.reg_c[RA_W-1:0];
        end
        else
        begin
            rd0_addr = item_reg.reg_a[RA_W-1:0];
            rd1_addr = item_reg.reg_c[RA_W-1:0];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        item_next       = item_reg;
        vb_next         = vb_reg;
        vc_next         = vc_reg;
        res_next        = res_reg;
        wr_next         = wr_reg;
        err_next        = err_reg;
        out_valid_next  = out_valid_reg;
        wrote_next      = wrote_reg;
        dest_index_next = dest_index_reg;
        dest_value_next = dest_value_reg;
        error_next      = error_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (!empty)
                begin
                    item_next  = head;
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                vb_next    = rd0_data_reg;
                vc_next    = rd1_data_reg;
                state_next = S_EXEC;
            end
            S_EXEC:
            begin
                // rd0_data_reg now holds the old value of A
                res_next   = rd0_data_reg;
                wr_next    = 1'b0;
                err_next   = 1'b0;
                state_next = S_WB;
                case (item_reg.cls)
                    CLS_MOVE:
                    begin
                        if (vc_reg != '0)
                        begin
                            res_next = vb_reg;
                            wr_next  = 1'b1;
                        end
                    end
                    CLS_ADD:
                    begin
                        res_next = vb_reg + vc_reg;
                        wr_next  = 1'b1;
                    end
                    CLS_MUL:
                    begin
                        res_next = product[DATA_W-1:0];
                        wr_next  = 1'b1;
                    end
                    CLS_DIV:
                    begin
                        if (vc_reg == '0)
                        begin
                            err_next = 1'b1;
                        end
                        else
                        begin
                            state_next = S_DIV;
                        end
                    end
                    CLS_NAND:
                    begin
                        res_next = ~(vb_reg & vc_reg);
                        wr_next  = 1'b1;
                    end
                    CLS_LDI:
                    begin
                        res_next = {{(DATA_W-IMM_W){1'b0}}, item_reg.immediate};
                        wr_next  = 1'b1;
                    end
                    default:
                    begin
                        wr_next = 1'b0;
                    end
                endcase
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    res_next   = div_quotient;
                    wr_next    = 1'b1;
                    state_next = S_WB;
                end
            end
            S_WB:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    wrote_next      = wr_reg;
                    dest_index_next = item_reg.reg_a;
                    dest_value_next = res_reg;
                    error_next      = err_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            rf_valid_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            if (rf_we)
            begin
                rf_valid_reg[item_reg.reg_a[RA_W-1:0]] <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg       <= item_next;
        vb_reg         <= vb_next;
        vc_reg         <= vc_next;
        res_reg        <= res_next;
        wr_reg         <= wr_next;
        err_reg        <= err_next;
        wrote_reg      <= wrote_next;
        dest_index_reg <= dest_index_next;
        dest_value_reg <= dest_value_next;
        error_reg      <= error_next;
    end

    // Register file: one write port, two registered read ports.
    // Entries never written since reset read as zero.
    always_ff @(posedge clk)
    begin
        if (rf_we)
        begin
            rf_reg[item_reg.reg_a[RA_W-1:0]] <= res_reg;
        end
        rd0_data_reg <= rf_valid_reg[rd0_addr] ? rf_reg[rd0_addr] : '0;
        rd1_data_reg <= rf_valid_reg[rd1_addr] ? rf_reg[rd1_addr] : '0;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/um32_register_alu_execute.sv =====
// Top level of the um32 register ALU execute unit.
// Joins um32_front, um32_queue and um32_back; depends on um32_pkg.
`default_nettype none

//  Channel  | Handshake            | Fields
//  ---------+----------------------+--------------------------------------------
//  input    | in_valid, in_stall   | cmd, reg_a, reg_b, reg_c, immediate
//  output   | out_valid, out_stall | wrote, dest_index, dest_value, error
//
// An input transfer is taken into the front register, classified and moved to a
// two-entry queue. The back end takes one item at a time: it pops the queue,
// reads B and C, then A, from the register file, and executes. Move, add,
// multiply, nand, load immediate, divide by zero and unused codes go from pop
// through S_RDA, S_EXEC and S_WB to the result register; a divide by a nonzero
// value also waits in S_DIV for the radix-2 divider, one quotient bit per
// cycle, so divides set the sustained rate.
// Reset clears all control state and marks every register as zero; no clearing
// pass is needed. A stalled output holds the result register, the back end then
// waits in write-back, the queue fills and in_stall rises; the front keeps
// accepting one more item while the result waits to be taken.

module um32_register_alu_execute #(
    parameter int NUM_REGS = 8
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [2:0]  cmd,
    input  logic [2:0]  reg_a,
    input  logic [2:0]  reg_b,
    input  logic [2:0]  reg_c,
    input  logic [24:0] immediate,
    output logic        out_valid,
    input  logic        out_stall,
    output logic        wrote,
    output logic [2:0]  dest_index,
    output logic [31:0] dest_value,
    output logic        error
);
    import um32_pkg::*;

    logic       q_full;
    logic       q_empty;
    logic       q_push;
    logic       q_pop;
    um32_item_t q_push_item;
    um32_item_t q_head;

    um32_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .cmd       (cmd),
        .reg_a     (reg_a),
        .reg_b     (reg_b),
        .reg_c     (reg_c),
        .immediate (immediate),
        .q_full    (q_full),
        .push      (q_push),
        .push_item (q_push_item)
    );

    um32_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head      (q_head),
        .full      (q_full),
        .empty     (q_empty)
    );

    um32_back #(
        .NUM_REGS (NUM_REGS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (q_head),
        .empty      (q_empty),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .wrote      (wrote),
        .dest_index (dest_index),
        .dest_value (dest_value),
        .error      (error)
    );

endmodule

`default_nettype wire

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for the um32 register ALU execute unit.
// Depends on um32_pkg and um32_register_alu_execute; holds its own register-file
// predictor, a queue-fed input driver, an output monitor and a watchdog.
`timescale 1ns / 100ps

module tb_top;

    import um32_pkg::*;

    // Codes six and seven are not operations; the unit must leave the file untouched.
    localparam logic [2:0] CMD_SPARE6 = 3'd6;
    localparam logic [2:0] CMD_SPARE7 = 3'd7;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 80;
    localparam int RANDOM_ITEMS   = 550;

    // Idling regimes, run in this order.
    typedef enum logic [1:0] {
        PH_RECV_SLOW,
        PH_SEND_SLOW,
        PH_FREE
    } phase_t;

    typedef struct packed {
        logic [2:0]       op;
        logic [IDX_W-1:0] a;
        logic [IDX_W-1:0] b;
        logic [IDX_W-1:0] c;
        logic [IMM_W-1:0] imm;
    } alu_cmd_t;

    typedef struct packed {
        logic              wrote;
        logic [IDX_W-1:0]  dest_index;
        logic [DATA_W-1:0] dest_value;
        logic              error;
    } writeback_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [2:0]        cmd = '0;
    logic [2:0]        reg_a = '0;
    logic [2:0]        reg_b = '0;
    logic [2:0]        reg_c = '0;
    logic [24:0]       immediate = '0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic              wrote;
    logic [2:0]        dest_index;
    logic [31:0]       dest_value;
    logic              error;

    // Commands waiting to be offered, and write-backs waiting to come out.
    alu_cmd_t   issue_q[$];
    writeback_t writeback_q[$];

    // The testbench's own copy of the architectural register file.
    logic [DATA_W-1:0] arch_regs [8];

    phase_t phase = PH_RECV_SLOW;
    int     send_idle_pct = 29;
    int     recv_idle_pct = 66;
    int     fail_count = 0;
    int     quiet_cycles = 0;
    int     hold_left = 0;
    bit     held_done = 1'b0;

    // Coverage tallies for the closing summary.
    int op_seen [8];
    int div_by_zero = 0;
    int cmov_skipped = 0;
    int results_seen = 0;

    um32_register_alu_execute u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .cmd        (cmd),
        .reg_a      (reg_a),
        .reg_b      (reg_b),
        .reg_c      (reg_c),
        .immediate  (immediate),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .wrote      (wrote),
        .dest_index (dest_index),
        .dest_value (dest_value),
        .error      (error)
    );

    // 4 ns period clock.
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Executes one command against the shadow register file and returns the
    // write-back it must produce. Both sources and the old destination are read
    // before anything is written, so aliased indices behave as in hardware.
    function automatic writeback_t predict_writeback(alu_cmd_t op_in);
        writeback_t        wb;
        logic [DATA_W-1:0] vb;
        logic [DATA_W-1:0] vc;
        vb            = arch_regs[op_in.b];
        vc            = arch_regs[op_in.c];
        wb.wrote      = 1'b0;
        wb.error      = 1'b0;
        wb.dest_index = op_in.a;
        wb.dest_value = arch_regs[op_in.a];
        op_seen[op_in.op]++;
        case (op_in.op)
            CMD_CMOV:
            begin
                if (vc != '0)
                begin
                    wb.dest_value = vb;
                    wb.wrote      = 1'b1;
                end
                else
                begin
                    cmov_skipped++;
                end
            end
            CMD_ADD:
            begin
                wb.dest_value = vb + vc;
                wb.wrote      = 1'b1;
            end
            CMD_MUL:
            begin
                // Both operands are 32 bits wide, so the product wraps modulo 2^32.
                wb.dest_value = vb * vc;
                wb.wrote      = 1'b1;
            end
            CMD_DIV:
            begin
                if (vc != '0)
                begin
                    wb.dest_value = vb / vc;
                    wb.wrote      = 1'b1;
                end
                else
                begin
                    wb.error = 1'b1;
                    div_by_zero++;
                end
            end
            CMD_NAND:
            begin
                wb.dest_value = ~(vb & vc);
                wb.wrote      = 1'b1;
            end
            CMD_LDI:
            begin
                wb.dest_value = {{(DATA_W-IMM_W){1'b0}}, op_in.imm};
                wb.wrote      = 1'b1;
            end
            default:
            begin
            end
        endcase
        if (wb.wrote)
        begin
            arch_regs[op_in.a] = wb.dest_value;
        end
        return wb;
    endfunction

    // Input driver. The offered command is held while the unit stalls; once a
    // transfer completes (or nothing is offered) the slot is either refilled from
    // the issue queue or left empty, decided by a coin that never looks at stall.
    always @(posedge clk)
    begin : drive_commands
        alu_cmd_t   next_cmd;
        alu_cmd_t   taken;
        writeback_t wb;
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && !in_stall)
            begin
                taken.op  = cmd;
                taken.a   = reg_a;
                taken.b   = reg_b;
                taken.c   = reg_c;
                taken.imm = immediate;
                wb = predict_writeback(taken);
                writeback_q.push_back(wb);
            end
            if (!in_valid || !in_stall)
            begin
                if (issue_q.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    next_cmd = issue_q.pop_front();
                    cmd       <= next_cmd.op;
                    reg_a     <= next_cmd.a;
                    reg_b     <= next_cmd.b;
                    reg_c     <= next_cmd.c;
                    immediate <= next_cmd.imm;
                    in_valid  <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic report_mismatch(string field, longint unsigned want, longint unsigned got);
        $error("%s mismatch: expected 0x%0h, got 0x%0h", field, want, got);
        fail_count++;
    endtask

    // Output monitor. Every write-back transfer is checked field by field against
    // the oldest prediction. The stall it drives is random, except for a single
    // long hold at the start of the no-idling phase: the sender keeps offering
    // during it, so the internal queue fills and the input side must stall.
    always @(posedge clk)
    begin : check_writebacks
        writeback_t want;
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (writeback_q.size() == 0)
                begin
                    report_mismatch("unexpected result, dest_value", '0, dest_value);
                end
                else
                begin
                    want = writeback_q.pop_front();
                    if (wrote !== want.wrote)
                    begin
                        report_mismatch("wrote", want.wrote, wrote);
                    end
                    if (dest_index !== want.dest_index)
                    begin
                        report_mismatch("dest_index", want.dest_index, dest_index);
                    end
                    if (dest_value !== want.dest_value)
                    begin
                        report_mismatch("dest_value", want.dest_value, dest_value);
                    end
                    if (error !== want.error)
                    begin
                        report_mismatch("error", want.error, error);
                    end
                end
            end
            if (phase == PH_FREE && !held_done)
            begin
                held_done = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
            end
        end
    end

    // Watchdog: too long without any transfer on either channel means a hang.
    always @(posedge clk)
    begin
        if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall)))
        begin
            quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
                $display("TEST FAILED");
                $finish;
            end
        end
        else
        begin
            quiet_cycles = 0;
        end
    end

    task automatic queue_cmd(logic [2:0] op, logic [2:0] a, logic [2:0] b, logic [2:0] c,
                             logic [24:0] imm);
        alu_cmd_t item;
        item.op  = op;
        item.a   = a;
        item.b   = b;
        item.c   = c;
        item.imm = imm;
        issue_q.push_back(item);
    endtask

    // Random command stream. Load immediate is frequent so that registers keep
    // changing, with small values mixed in so that divides give varied
    // quotients. Spare codes make up a small share of noise.
    task automatic queue_random(int count);
        int          pick;
        logic [2:0]  op;
        logic [24:0] imm;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 20)
                op = CMD_LDI;
            else if (pick < 33)
                op = CMD_ADD;
            else if (pick < 45)
                op = CMD_MUL;
            else if (pick < 58)
                op = CMD_DIV;
            else if (pick < 70)
                op = CMD_NAND;
            else if (pick < 90)
                op = CMD_CMOV;
            else if (pick < 95)
                op = CMD_SPARE6;
            else
                op = CMD_SPARE7;
            case ($urandom_range(0, 3))
                0: imm = IMM_W'($urandom_range(0, 15));
                1: imm = {IMM_W{1'b1}};
                default: imm = IMM_W'($urandom);
            endcase
            queue_cmd(op, 3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)),
                      3'($urandom_range(0, 7)), imm);
        end
    endtask

    // Waits until every queued command has been taken and every write-back has come.
    task automatic drain;
        while (issue_q.size() != 0 || in_valid || writeback_q.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    initial
    begin
        for (int r = 0; r < 8; r++)
        begin
            arch_regs[r] = '0;
        end
        for (int k = 0; k < 8; k++)
        begin
            op_seen[k] = 0;
        end
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed opening: all registers are zero, so the conditional move and
        // the divide both hit their no-write cases first. Then the extremes of
        // the immediate, all-ones from nand, wrapping add and multiply, divides
        // with extreme operands, aliased indices and the spare codes.
        queue_cmd(CMD_CMOV,   3'd1, 3'd2, 3'd3, 25'd0);
        queue_cmd(CMD_DIV,    3'd2, 3'd1, 3'd0, 25'd0);
        queue_cmd(CMD_SPARE6, 3'd3, 3'd0, 3'd0, 25'd0);
        queue_cmd(CMD_SPARE7, 3'd4, 3'd5, 3'd6, 25'd0);
        queue_cmd(CMD_LDI,    3'd0, 3'd0, 3'd0, {IMM_W{1'b1}});
        queue_cmd(CMD_LDI,    3'd1, 3'd7, 3'd7, 25'd0);
        queue_cmd(CMD_NAND,   3'd7, 3'd1, 3'd1, 25'd0);
        queue_cmd(CMD_ADD,    3'd6, 3'd7, 3'd7, 25'd0);
        queue_cmd(CMD_MUL,    3'd5, 3'd7, 3'd7, 25'd0);
        queue_cmd(CMD_MUL,    3'd4, 3'd0, 3'd7, 25'd0);
        queue_cmd(CMD_DIV,    3'd3, 3'd7, 3'd0, 25'd0);
        queue_cmd(CMD_DIV,    3'd2, 3'd5, 3'd7, 25'd0);
        queue_cmd(CMD_DIV,    3'd2, 3'd7, 3'd5, 25'd0);
        queue_cmd(CMD_CMOV,   3'd1, 3'd7, 3'd5, 25'd0);
        queue_cmd(CMD_NAND,   3'd0, 3'd0, 3'd7, 25'd0);
        queue_cmd(CMD_ADD,    3'd3, 3'd3, 3'd3, 25'd0);
        queue_cmd(CMD_LDI,    3'd5, 3'd0, 3'd0, 25'd0);
        queue_cmd(CMD_DIV,    3'd6, 3'd6, 3'd5, 25'd0);
        queue_cmd(CMD_SPARE6, 3'd7, 3'd7, 3'd7, {IMM_W{1'b1}});
        queue_cmd(CMD_CMOV,   3'd2, 3'd2, 3'd2, 25'd0);
        queue_random(RANDOM_ITEMS);
        drain();

        // Swap the idling: the sender is now the slow side.
        @(negedge clk);
        phase         = PH_SEND_SLOW;
        send_idle_pct = 66;
        recv_idle_pct = 29;
        queue_random(RANDOM_ITEMS);
        drain();

        // No idling on either side, opened by the long output hold.
        @(negedge clk);
        phase         = PH_FREE;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        queue_random(RANDOM_ITEMS);
        drain();

        // A divide is the slowest command; let any stray output show up.
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Checked %0d write-backs: cmov %0d (%0d on a zero condition), add %0d, mul %0d,",
                 results_seen, op_seen[CMD_CMOV], cmov_skipped, op_seen[CMD_ADD],
                 op_seen[CMD_MUL]);
        $display("div %0d (%0d by zero), nand %0d, ldi %0d, spare codes %0d; three idling regimes.",
                 op_seen[CMD_DIV], div_by_zero, op_seen[CMD_NAND], op_seen[CMD_LDI],
                 op_seen[CMD_SPARE6] + op_seen[CMD_SPARE7]);
        if (fail_count == 0)
        begin
            $display("TEST PASSED");
        end
        else
        begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
